>>> design/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared types, constants and the byte layout decode for the 4:2:2 to RGB
// converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int ChanW = 8;
  localparam int LumaW = 19;   // floored (Y-16)*1192, never negative
  localparam int TermW = 20;   // signed chroma term with its offset
  localparam int ProdW = 22;   // widest intermediate product or sum
  localparam int FracW = 10;

  localparam logic signed [12:0] COEF_Y    = 13'sd1192;
  localparam logic signed [12:0] COEF_VR   = 13'sd1634;
  localparam logic signed [12:0] COEF_VG   = -13'sd832;
  localparam logic signed [12:0] COEF_UG   = -13'sd400;
  localparam logic signed [12:0] COEF_UB   = 13'sd2066;
  localparam logic signed [12:0] TERM_ONE  = 13'sd1024;
  localparam logic signed [8:0]  LUMA_OFS  = 9'sd16;
  localparam logic signed [8:0]  CHROMA_OFS = 9'sd128;
  localparam logic signed [ProdW-1:0] SUM_MAX = ProdW'(255 << FracW);

  // Byte layouts selected by the byte_order register.
  localparam logic [2:0] ORD_YUYV       = 3'd0;
  localparam logic [2:0] ORD_UYVY       = 3'd1;
  localparam logic [2:0] ORD_VYUY       = 3'd2;
  localparam logic [2:0] ORD_YVYU       = 3'd3;
  localparam logic [2:0] ORD_UYVY_SWAPY = 3'd4;
  localparam logic [2:0] ORD_VYUY_SWAPY = 3'd5;
  localparam logic [2:0] ORD_YUYV_SWAPY = 3'd6;
  localparam logic [2:0] ORD_YVYU_SWAPY = 3'd7;

  // Register word index on the configuration bus.
  localparam logic REG_BYTE_ORDER = 1'b0;

  typedef logic [1:0] pos_t;

  typedef struct packed {
    pos_t v;
    pos_t u;
    pos_t y2;
    pos_t y1;
  } layout_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctrl_t;

  typedef struct packed {
    logic [ChanW-1:0] y1;
    logic [ChanW-1:0] y2;
    logic [ChanW-1:0] u;
    logic [ChanW-1:0] v;
  } pix_t;

  typedef struct packed {
    logic        [LumaW-1:0] luma1;
    logic        [LumaW-1:0] luma2;
    logic signed [TermW-1:0] r_term;
    logic signed [TermW-1:0] g_term;
    logic signed [TermW-1:0] b_term;
  } terms_t;

  function automatic layout_t layout_of(input logic [2:0] order);
    layout_t lay;
    case (order)
      ORD_YUYV:       lay = '{v: 2'd3, u: 2'd1, y2: 2'd2, y1: 2'd0};
      ORD_UYVY:       lay = '{v: 2'd2, u: 2'd0, y2: 2'd3, y1: 2'd1};
      ORD_VYUY:       lay = '{v: 2'd0, u: 2'd2, y2: 2'd3, y1: 2'd1};
      ORD_YVYU:       lay = '{v: 2'd1, u: 2'd3, y2: 2'd2, y1: 2'd0};
      ORD_UYVY_SWAPY: lay = '{v: 2'd2, u: 2'd0, y2: 2'd1, y1: 2'd3};
      ORD_VYUY_SWAPY: lay = '{v: 2'd0, u: 2'd2, y2: 2'd1, y1: 2'd3};
      ORD_YUYV_SWAPY: lay = '{v: 2'd3, u: 2'd1, y2: 2'd0, y1: 2'd2};
      ORD_YVYU_SWAPY: lay = '{v: 2'd1, u: 2'd3, y2: 2'd0, y1: 2'd2};
      default:        lay = '{v: 2'd3, u: 2'd1, y2: 2'd2, y1: 2'd0};
    endcase
    return lay;
  endfunction

endpackage

>>> design/y2r_unpack.sv
// ----------------------------------------------------------------------------
// y2r_unpack
// First pipeline stage: picks Y1, Y2, U and V out of the packed word.
// ----------------------------------------------------------------------------
module y2r_unpack (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        byte_order,
  input  y2r_pkg::ctrl_t    up_ctrl,
  input  logic [31:0]       up_word,
  output logic              up_ready,
  output y2r_pkg::ctrl_t    dn_ctrl,
  output y2r_pkg::pix_t     dn_pix,
  input  logic              dn_ready
);
  import y2r_pkg::*;

  layout_t lay;
  pix_t    pix_nxt;
  ctrl_t   ctrl_r;
  pix_t    pix_r;

  function automatic logic [ChanW-1:0] pick(input logic [31:0] word, input pos_t pos);
    return word[{pos, 3'b000} +: ChanW];
  endfunction

  always_comb begin
    lay        = layout_of(byte_order);
    pix_nxt.y1 = pick(up_word, lay.y1);
    pix_nxt.y2 = pick(up_word, lay.y2);
    pix_nxt.u  = pick(up_word, lay.u);
    pix_nxt.v  = pick(up_word, lay.v);
  end

  assign up_ready = !ctrl_r.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (up_ready) begin
      ctrl_r <= up_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctrl.valid) begin
      pix_r <= pix_nxt;
    end
  end

  assign dn_ctrl = ctrl_r;
  assign dn_pix  = pix_r;

endmodule

>>> design/y2r_mult.sv
// ----------------------------------------------------------------------------
// y2r_mult
// Second pipeline stage: luma and chroma products in Q10.
// ----------------------------------------------------------------------------
module y2r_mult (
  input  logic              clk,
  input  logic              rst_n,
  input  y2r_pkg::ctrl_t    up_ctrl,
  input  y2r_pkg::pix_t     up_pix,
  output logic              up_ready,
  output y2r_pkg::ctrl_t    dn_ctrl,
  output y2r_pkg::terms_t   dn_terms,
  input  logic              dn_ready
);
  import y2r_pkg::*;

  logic signed [8:0]       y1_c, y2_c, u_c, v_c;
  logic signed [ProdW-1:0] l1_full, l2_full, r_full, g_full, b_full;
  terms_t                  terms_nxt;
  ctrl_t                   ctrl_r;
  terms_t                  terms_r;

  always_comb begin
    y1_c = $signed({1'b0, up_pix.y1}) - LUMA_OFS;
    y2_c = $signed({1'b0, up_pix.y2}) - LUMA_OFS;
    u_c  = $signed({1'b0, up_pix.u}) - CHROMA_OFS;
    v_c  = $signed({1'b0, up_pix.v}) - CHROMA_OFS;

    l1_full = ProdW'(y1_c) * ProdW'(COEF_Y);
    l2_full = ProdW'(y2_c) * ProdW'(COEF_Y);
    r_full  = ProdW'(TERM_ONE) + ProdW'(COEF_VR) * ProdW'(v_c);
    g_full  = ProdW'(TERM_ONE) + ProdW'(COEF_VG) * ProdW'(v_c)
            + ProdW'(COEF_UG) * ProdW'(u_c);
    b_full  = ProdW'(TERM_ONE) + ProdW'(COEF_UB) * ProdW'(u_c);

    // Luma below the black level contributes nothing.
    terms_nxt.luma1  = l1_full[ProdW-1] ? '0 : l1_full[LumaW-1:0];
    terms_nxt.luma2  = l2_full[ProdW-1] ? '0 : l2_full[LumaW-1:0];
    terms_nxt.r_term = r_full[TermW-1:0];
    terms_nxt.g_term = g_full[TermW-1:0];
    terms_nxt.b_term = b_full[TermW-1:0];
  end

  assign up_ready = !ctrl_r.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (up_ready) begin
      ctrl_r <= up_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctrl.valid) begin
      terms_r <= terms_nxt;
    end
  end

  assign dn_ctrl  = ctrl_r;
  assign dn_terms = terms_r;

endmodule

>>> design/y2r_clamp.sv
// ----------------------------------------------------------------------------
// y2r_clamp
// Third pipeline stage and output register: adds luma and chroma, clamps to
// the 8-bit range and drops the fraction.
// ----------------------------------------------------------------------------
module y2r_clamp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  y2r_pkg::ctrl_t            up_ctrl,
  input  y2r_pkg::terms_t           up_terms,
  output logic                      up_ready,
  output y2r_pkg::ctrl_t            dn_ctrl,
  output logic [y2r_pkg::ChanW-1:0] red_first,
  output logic [y2r_pkg::ChanW-1:0] green_first,
  output logic [y2r_pkg::ChanW-1:0] blue_first,
  output logic [y2r_pkg::ChanW-1:0] red_second,
  output logic [y2r_pkg::ChanW-1:0] green_second,
  output logic [y2r_pkg::ChanW-1:0] blue_second,
  input  logic                      dn_ready
);
  import y2r_pkg::*;

  ctrl_t            ctrl_r;
  logic [ChanW-1:0] rf_r, gf_r, bf_r, rs_r, gs_r, bs_r;

  function automatic logic [ChanW-1:0] chan(input logic [LumaW-1:0] luma,
                                            input logic signed [TermW-1:0] term);
    logic signed [ProdW-1:0] s;
    logic [ChanW-1:0]        res;
    s = ProdW'($signed({1'b0, luma})) + ProdW'(term);
    if (s[ProdW-1]) begin
      res = '0;
    end else if (s > SUM_MAX) begin
      res = '1;
    end else begin
      res = s[FracW +: ChanW];
    end
    return res;
  endfunction

  assign up_ready = !ctrl_r.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (up_ready) begin
      ctrl_r <= up_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctrl.valid) begin
      rf_r <= chan(up_terms.luma1, up_terms.r_term);
      gf_r <= chan(up_terms.luma1, up_terms.g_term);
      bf_r <= chan(up_terms.luma1, up_terms.b_term);
      rs_r <= chan(up_terms.luma2, up_terms.r_term);
      gs_r <= chan(up_terms.luma2, up_terms.g_term);
      bs_r <= chan(up_terms.luma2, up_terms.b_term);
    end
  end

  assign dn_ctrl      = ctrl_r;
  assign red_first    = rf_r;
  assign green_first  = gf_r;
  assign blue_first   = bf_r;
  assign red_second   = rs_r;
  assign green_second = gs_r;
  assign blue_second  = bs_r;

endmodule

>>> design/yuv422_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// yuv422_to_rgb_converter
// Each accepted word moves through the unpack, multiply and clamp registers to out_valid.
// Throughput: one packed word (two pixels) per cycle, set by the three-stage
// unpack / multiply / clamp pipeline; a stalled output holds the pipe.
// Reset (rst_n low, synchronous) empties the pipeline and sets byte_order to
// YUYV.
// ----------------------------------------------------------------------------
module yuv422_to_rgb_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_packed_word,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_first,
  output logic [7:0]  out_green_first,
  output logic [7:0]  out_blue_first,
  output logic [7:0]  out_red_second,
  output logic [7:0]  out_green_second,
  output logic [7:0]  out_blue_second,
  output logic        out_last_pair
);
  import y2r_pkg::*;

  logic [2:0] byte_order_r;
  logic [2:0] byte_order_nxt;
  logic       cfg_write;
  logic       cfg_sel_order;

  ctrl_t  in_ctrl, s1_ctrl, s2_ctrl, s3_ctrl;
  pix_t   s1_pix;
  terms_t s2_terms;
  logic   s1_ready, s2_ready, s3_ready;

  // Configuration port
  assign pready        = 1'b1;
  assign cfg_sel_order = (paddr[2] == REG_BYTE_ORDER);
  assign cfg_write     = psel && penable && pwrite && pready;

  always_comb begin
    byte_order_nxt = byte_order_r;
    if (cfg_write && cfg_sel_order) begin
      byte_order_nxt = pwdata[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_order_r <= ORD_YUYV;
    end else begin
      byte_order_r <= byte_order_nxt;
    end
  end

  assign prdata = cfg_sel_order ? {29'd0, byte_order_r} : 32'd0;

  // Pipeline
  assign in_ctrl = '{valid: in_valid, last: in_last_word};

  y2r_unpack u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_order (byte_order_r),
    .up_ctrl    (in_ctrl),
    .up_word    (in_packed_word),
    .up_ready   (s1_ready),
    .dn_ctrl    (s1_ctrl),
    .dn_pix     (s1_pix),
    .dn_ready   (s2_ready)
  );

  y2r_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_ctrl  (s1_ctrl),
    .up_pix   (s1_pix),
    .up_ready (s2_ready),
    .dn_ctrl  (s2_ctrl),
    .dn_terms (s2_terms),
    .dn_ready (s3_ready)
  );

  y2r_clamp u_clamp (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_ctrl      (s2_ctrl),
    .up_terms     (s2_terms),
    .up_ready     (s3_ready),
    .dn_ctrl      (s3_ctrl),
    .red_first    (out_red_first),
    .green_first  (out_green_first),
    .blue_first   (out_blue_first),
    .red_second   (out_red_second),
    .green_second (out_green_second),
    .blue_second  (out_blue_second),
    .dn_ready     (!out_stall)
  );

  assign in_stall      = !s1_ready;
  assign out_valid     = s3_ctrl.valid;
  assign out_last_pair = s3_ctrl.last;

`ifndef SYNTHESIS
  // The input may only stall when every stage is full and the output is held.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_ctrl.valid && s2_ctrl.valid && out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  // A transfer with a free-running output reaches out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted word did not reach the output in time");

  // A register write lands in byte_order on the next edge.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_write && cfg_sel_order) |=> (byte_order_r == $past(pwdata[2:0])))
    else $error("byte_order write was lost");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !s1_ctrl.valid && !s2_ctrl.valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yuv422_to_rgb_converter testbench
// Streams packed 4:2:2 words through the converter under every byte layout
// and compares each RGB pixel pair with a fixed-point prediction. Both sides
// of the stream idle at random, and the layout register is written over the
// APB-style port between phases.
// ----------------------------------------------------------------------------
module testbench;
  import y2r_pkg::*;

  localparam int        PipeLatency     = 3;
  localparam int        CycleLimit      = 200_000;
  localparam logic [2:0] ADDR_BYTE_ORDER = {REG_BYTE_ORDER, 2'b00};
  localparam logic [2:0] ADDR_UNUSED     = 3'd4;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       last_pair;
  } rgb_pair_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_packed_word = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red_first;
  logic [7:0]  out_green_first;
  logic [7:0]  out_blue_first;
  logic [7:0]  out_red_second;
  logic [7:0]  out_green_second;
  logic [7:0]  out_blue_second;
  logic        out_last_pair;

  rgb_pair_t   pending_pairs[$];
  logic [2:0]  order_copy = ORD_YUYV;
  bit          no_idle = 1'b0;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          stall_left = 0;

  yuv422_to_rgb_converter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_packed_word   (in_packed_word),
    .in_last_word     (in_last_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red_first    (out_red_first),
    .out_green_first  (out_green_first),
    .out_blue_first   (out_blue_first),
    .out_red_second   (out_red_second),
    .out_green_second (out_green_second),
    .out_blue_second  (out_blue_second),
    .out_last_pair    (out_last_pair)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int luma_of(input int y);
    int t;
    t = (y - 16) * 1192;
    return (t < 0) ? 0 : t;
  endfunction

  function automatic logic [7:0] clamp_channel(input int luma, input int term);
    int s;
    s = luma + term;
    if (s > (255 << 10)) s = 255 << 10;
    if (s < 0) s = 0;
    return 8'(s >> 10);
  endfunction

  function automatic rgb_pair_t predict_pair(input logic [31:0] word, input logic last,
                                             input logic [2:0] order);
    int        p_y1, p_y2, p_u, p_v;
    int        l1, l2, u, v, rt, gt, bt;
    rgb_pair_t pair;
    case (order)
      ORD_YUYV:       begin p_y1 = 0; p_y2 = 2; p_u = 1; p_v = 3; end
      ORD_UYVY:       begin p_y1 = 1; p_y2 = 3; p_u = 0; p_v = 2; end
      ORD_VYUY:       begin p_y1 = 1; p_y2 = 3; p_u = 2; p_v = 0; end
      ORD_YVYU:       begin p_y1 = 0; p_y2 = 2; p_u = 3; p_v = 1; end
      ORD_UYVY_SWAPY: begin p_y1 = 3; p_y2 = 1; p_u = 0; p_v = 2; end
      ORD_VYUY_SWAPY: begin p_y1 = 3; p_y2 = 1; p_u = 2; p_v = 0; end
      ORD_YUYV_SWAPY: begin p_y1 = 2; p_y2 = 0; p_u = 1; p_v = 3; end
      default:        begin p_y1 = 2; p_y2 = 0; p_u = 3; p_v = 1; end
    endcase
    l1 = luma_of(int'(word[p_y1*8 +: 8]));
    l2 = luma_of(int'(word[p_y2*8 +: 8]));
    u  = int'(word[p_u*8 +: 8]) - 128;
    v  = int'(word[p_v*8 +: 8]) - 128;
    rt = 1024 + 1634 * v;
    gt = 1024 - 832 * v - 400 * u;
    bt = 1024 + 2066 * u;
    pair.red_first    = clamp_channel(l1, rt);
    pair.green_first  = clamp_channel(l1, gt);
    pair.blue_first   = clamp_channel(l1, bt);
    pair.red_second   = clamp_channel(l2, rt);
    pair.green_second = clamp_channel(l2, gt);
    pair.blue_second  = clamp_channel(l2, bt);
    pair.last_pair    = last;
    return pair;
  endfunction

  // ------------------------------------------------------------ shared helpers

  function automatic int draw_idle();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [7:0] pick_component();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd16;
      3:       return 8'd15;
      4:       return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] random_word();
    if ($urandom_range(0, 3) == 0)
      return {pick_component(), pick_component(), pick_component(), pick_component()};
    return $urandom();
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Sends one word and records its expected pixel pair once the transfer is taken.
  task automatic send_word(input logic [31:0] word, input logic last);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_packed_word <= word;
    in_last_word   <= last;
    do @(posedge clk); while (in_stall);
    pending_pairs.push_back(predict_pair(word, last, order_copy));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (PipeLatency + 2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_BYTE_ORDER) order_copy = data[2:0];
    @(posedge clk);
  endtask

  task automatic cfg_check_order();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_BYTE_ORDER;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // prdata as seen here is the value during the access cycle.
    check_field("byte_order", 32'(order_copy), 32'(prdata[2:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ------------------------------------------------------------------- tests

  task automatic test_directed();
    // Words are built as {V, Y2, U, Y1} for the YUYV layout left by reset.
    cfg_check_order();
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word({8'd128, 8'd16, 8'd128, 8'd16}, 1'b0);    // luma exactly zero
    send_word({8'd128, 8'd15, 8'd128, 8'd0}, 1'b0);     // luma below the offset
    send_word({8'd128, 8'd235, 8'd128, 8'd255}, 1'b1);  // bright neutral, saturation
    send_word({8'd255, 8'd255, 8'd0, 8'd255}, 1'b0);    // red saturates, blue term negative
    send_word({8'd0, 8'd0, 8'd255, 8'd0}, 1'b0);        // red negative, blue large
    send_word({8'd255, 8'd16, 8'd255, 8'd16}, 1'b0);    // green negative
    send_word({8'd0, 8'd255, 8'd0, 8'd255}, 1'b0);      // green saturates
    send_word(32'h1234_5678, 1'b0);
    send_word(32'h8000_0001, 1'b1);
    send_word(32'h7FFF_FFFE, 1'b0);
    send_word(32'h5555_AAAA, 1'b1);
    drain();
  endtask

  task automatic test_byte_orders();
    for (int order = ORD_YUYV; order <= ORD_YVYU_SWAPY; order++) begin
      cfg_write(ADDR_BYTE_ORDER, 32'(order));
      cfg_check_order();
      for (int n = 0; n < 20; n++) send_word(random_word(), ($urandom_range(0, 7) == 0));
      drain();
    end
  endtask

  task automatic test_register_decode();
    // A write outside the register map must leave the layout alone.
    cfg_write(ADDR_UNUSED, 32'(ORD_VYUY_SWAPY));
    cfg_check_order();
    for (int n = 0; n < 10; n++) send_word(random_word(), 1'b0);
    drain();
    // Bits above the layout field are dropped.
    cfg_write(ADDR_BYTE_ORDER, 32'hA5A5_A5A0 | 32'(ORD_YVYU));
    cfg_check_order();
    for (int n = 0; n < 10; n++) send_word(random_word(), ($urandom_range(0, 1) == 1));
    drain();
  endtask

  task automatic test_random();
    logic [2:0] order;
    for (int seg = 0; seg < 10; seg++) begin
      if (seg == 0)      order = ORD_YVYU_SWAPY;
      else if (seg == 1) order = ORD_YUYV;
      else               order = 3'($urandom_range(0, 7));
      cfg_write(ADDR_BYTE_ORDER, {29'($urandom_range(0, 32'h1FFF_FFFF)), order});
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 60; n++) send_word(random_word(), ($urandom_range(0, 7) == 0));
      drain();
    end
    no_idle = 1'b0;
  endtask

  // ----------------------------------------------------------- result side

  // Each result draws how long the next one is held off.
  always @(posedge clk) begin : rx_stall
    int hold;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      hold = draw_idle();
      stall_left <= hold;
      out_stall  <= (hold != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin : pair_checker
    rgb_pair_t exp_pair;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        $error("pixel pair transfer with no expected pair waiting");
        fail_count++;
      end else begin
        exp_pair = pending_pairs.pop_front();
        check_field("red_first", 32'(exp_pair.red_first), 32'(out_red_first));
        check_field("green_first", 32'(exp_pair.green_first), 32'(out_green_first));
        check_field("blue_first", 32'(exp_pair.blue_first), 32'(out_blue_first));
        check_field("red_second", 32'(exp_pair.red_second), 32'(out_red_second));
        check_field("green_second", 32'(exp_pair.green_second), 32'(out_green_second));
        check_field("blue_second", 32'(exp_pair.blue_second), 32'(out_blue_second));
        check_field("last_pair", 32'(exp_pair.last_pair), 32'(out_last_pair));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_byte_orders();
    test_register_decode();
    test_random();
    drain();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
